// File: design/rpb_pkg.sv
// ----------------------------------------------------------------------------
// rpb_pkg
// Shared types and constants for the palette pixel blitter.
// ----------------------------------------------------------------------------
package rpb_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int COORD_WIDTH     = 12;
  localparam int PAL_AW          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int PAL_CNT_W       = 9;
  localparam int EDGE_W          = 12;
  localparam int CLIP_W          = 13;
  localparam int CMP_W           = ((COORD_WIDTH > CLIP_W) ? COORD_WIDTH : CLIP_W) + 1;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int RGB_W           = 24;

  // queue depths, powers of two
  localparam int MID_DEPTH = 2;
  localparam int MID_AW    = $clog2(MID_DEPTH);
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = OUT_AW + 1;

  localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;
  localparam logic [31:0] RGB_MASK     = 32'h00FF_FFFF;

  localparam logic [CLIP_W-1:0]    CLIP_RESET  = CLIP_W'(4096);
  localparam logic [PAL_CNT_W-1:0] COUNT_RESET = PAL_CNT_W'(256);

  typedef enum logic [1:0] {
    MODE_INDEXED = 2'd0,
    MODE_COPY8   = 2'd1,
    MODE_COPY32  = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic {
    CMD_PALETTE = 1'b0,
    CMD_PIXEL   = 1'b1
  } command_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLIT_MODE     = 3'd0,
    REG_KEY_ENABLE    = 3'd1,
    REG_KEY_VALUE     = 3'd2,
    REG_CLIP_LEFT     = 3'd3,
    REG_CLIP_TOP      = 3'd4,
    REG_CLIP_WIDTH    = 3'd5,
    REG_CLIP_HEIGHT   = 3'd6,
    REG_PALETTE_COUNT = 3'd7
  } reg_e;

  typedef enum logic [1:0] {
    OP_PAL_WRITE = 2'd0,
    OP_LOOKUP    = 2'd1,
    OP_DIRECT    = 2'd2,
    OP_SKIP      = 2'd3
  } op_e;

  typedef struct packed {
    mode_e                 mode;
    logic                  key_en;
    logic [31:0]           key;
    logic [EDGE_W-1:0]     left;
    logic [EDGE_W-1:0]     top;
    logic [CLIP_W-1:0]     width;
    logic [CLIP_W-1:0]     height;
    logic [PAL_CNT_W-1:0]  pal_count;
  } cfg_t;

  typedef struct packed {
    op_e                   op;
    logic [7:0]            index;
    logic                  hit;
    logic [31:0]           value;
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
  } cmd_t;

  typedef struct packed {
    logic                   we;
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
    logic [31:0]            value;
  } result_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] count;
    logic                 busy;
  } bk_status_t;

endpackage

// File: design/rpb_ram.sv
// ----------------------------------------------------------------------------
// rpb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpb_ram #(
  parameter int Width = 24,
  parameter int Depth = 256
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/rpb_front.sv
// ----------------------------------------------------------------------------
// rpb_front
// Classifies each input beat: clip test, color key test, mode decode.
// ----------------------------------------------------------------------------
module rpb_front import rpb_pkg::*; (
  input  cfg_t                   cfg_i,
  input  logic                   command_i,
  input  logic [7:0]             entry_index_i,
  input  logic [7:0]             red_i,
  input  logic [7:0]             green_i,
  input  logic [7:0]             blue_i,
  input  logic [31:0]            source_pixel_i,
  input  logic [COORD_WIDTH-1:0] dest_x_i,
  input  logic [COORD_WIDTH-1:0] dest_y_i,
  output cmd_t                   cmd_o
);

  logic [CMP_W-1:0] x_ext, y_ext, left_ext, top_ext, right_ext, bottom_ext;
  logic             in_clip, keyed, entry_ok, src_ok;

  always_comb begin
    x_ext      = CMP_W'(dest_x_i);
    y_ext      = CMP_W'(dest_y_i);
    left_ext   = CMP_W'(cfg_i.left);
    top_ext    = CMP_W'(cfg_i.top);
    right_ext  = left_ext + CMP_W'(cfg_i.width);
    bottom_ext = top_ext + CMP_W'(cfg_i.height);
    in_clip    = (x_ext >= left_ext) && (x_ext < right_ext) &&
                 (y_ext >= top_ext) && (y_ext < bottom_ext);

    if (cfg_i.mode == MODE_COPY32) begin
      keyed = cfg_i.key_en && (source_pixel_i[23:0] == cfg_i.key[23:0]);
    end else begin
      keyed = cfg_i.key_en && (source_pixel_i[7:0] == cfg_i.key[7:0]);
    end

    entry_ok = {1'b0, entry_index_i} < PAL_CNT_W'(PALETTE_ENTRIES);
    src_ok   = ({1'b0, source_pixel_i[7:0]} < PAL_CNT_W'(PALETTE_ENTRIES)) &&
               ({1'b0, source_pixel_i[7:0]} < cfg_i.pal_count);

    cmd_o       = '0;
    cmd_o.op    = OP_SKIP;
    if (command_e'(command_i) == CMD_PALETTE) begin
      cmd_o.index = entry_index_i;
      cmd_o.value = {8'h00, red_i, green_i, blue_i};
      if (entry_ok) begin
        cmd_o.op = OP_PAL_WRITE;
      end
    end else begin
      cmd_o.x = dest_x_i;
      cmd_o.y = dest_y_i;
      if (in_clip && !keyed) begin
        case (cfg_i.mode)
          MODE_INDEXED: begin
            cmd_o.op    = OP_LOOKUP;
            cmd_o.index = source_pixel_i[7:0];
            cmd_o.hit   = src_ok;
          end
          MODE_COPY8: begin
            cmd_o.op    = OP_DIRECT;
            cmd_o.value = {24'h0, source_pixel_i[7:0]};
          end
          MODE_COPY32: begin
            cmd_o.op    = OP_DIRECT;
            cmd_o.value = source_pixel_i;
          end
          default: begin
            cmd_o.op = OP_SKIP;
          end
        endcase
      end
    end
  end

endmodule

// File: design/rpb_queue.sv
// ----------------------------------------------------------------------------
// rpb_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module rpb_queue import rpb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  cmd_t              mem_q [MID_DEPTH];
  logic [MID_AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [MID_AW:0]   count_q, count_d;
  logic              push, pop;

  assign push_ready_o = count_q < (MID_AW + 1)'(MID_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + MID_AW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + MID_AW'(1) : rd_ptr_q;
    count_d  = count_q + (MID_AW + 1)'(push) - (MID_AW + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: design/rpb_back.sv
// ----------------------------------------------------------------------------
// rpb_back
// Executes commands: palette writes, palette lookups, direct copies, and the result queue.
// ----------------------------------------------------------------------------
module rpb_back import rpb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  output logic       cmd_ready_o,
  input  cmd_t       cmd_i,
  output logic       res_valid_o,
  input  logic       res_pop_i,
  output result_t    res_o,
  output bk_status_t status_o
);

  logic [PALETTE_ENTRIES-1:0] pal_valid_q;
  logic [PAL_AW-1:0]          addr;
  logic [RGB_W-1:0]           rdata;
  logic                       issue, ram_we;

  logic       busy_q;
  result_t    s1_res_q;
  logic       s1_lookup_q, s1_hit_q, s1_entry_q;
  result_t    s1_out;

  result_t              out_mem_q [OUT_DEPTH];
  logic [OUT_AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [OUT_CNT_W-1:0] count_q;
  logic                 pop;

  assign cmd_ready_o = ((OUT_CNT_W + 1)'(count_q) + (OUT_CNT_W + 1)'(busy_q))
                       < (OUT_CNT_W + 1)'(OUT_DEPTH);
  assign issue  = cmd_valid_i && cmd_ready_o;
  assign addr   = cmd_i.index[PAL_AW-1:0];
  assign ram_we = issue && (cmd_i.op == OP_PAL_WRITE);

  rpb_ram #(
    .Width (RGB_W),
    .Depth (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr),
    .wdata_i (cmd_i.value[RGB_W-1:0]),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_valid_q <= '0;
      busy_q      <= 1'b0;
    end else begin
      if (ram_we) begin
        pal_valid_q[addr] <= 1'b1;
      end
      busy_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_res_q.we    <= (cmd_i.op == OP_LOOKUP) || (cmd_i.op == OP_DIRECT);
      s1_res_q.x     <= cmd_i.x;
      s1_res_q.y     <= cmd_i.y;
      s1_res_q.value <= (cmd_i.op == OP_DIRECT) ? cmd_i.value : '0;
      s1_lookup_q    <= cmd_i.op == OP_LOOKUP;
      s1_hit_q       <= cmd_i.hit;
      s1_entry_q     <= pal_valid_q[addr];
    end
  end

  always_comb begin
    s1_out = s1_res_q;
    if (s1_lookup_q) begin
      s1_out.value = ALPHA_OPAQUE;
      if (s1_hit_q && s1_entry_q) begin
        s1_out.value = ALPHA_OPAQUE | (32'(rdata) & RGB_MASK);
      end
    end
  end

  assign pop         = res_pop_i && (count_q != '0);
  assign res_valid_o = count_q != '0;
  assign res_o       = out_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (busy_q) begin
        wr_ptr_q <= wr_ptr_q + OUT_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OUT_AW'(1);
      end
      count_q <= count_q + OUT_CNT_W'(busy_q) - OUT_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      out_mem_q[wr_ptr_q] <= s1_out;
    end
  end

  assign status_o.count = count_q;
  assign status_o.busy  = busy_q;

endmodule

// File: design/palette_pixel_blit_with_key_and_clip.sv
// ----------------------------------------------------------------------------
// palette_pixel_blit_with_key_and_clip
// Per-pixel blitter back end: palette expansion, color key and clip.
// ----------------------------------------------------------------------------
// channel   ports                                      handshake
// input     command/entry_index/red/green/blue/        push, full
//           source_pixel/dest_x/dest_y
// result    write_enable/out_x/out_y/out_value         empty, pop
// config    cfg_we_i, cfg_idx_i, cfg_data_i            write enable only
//
// One beat per cycle sustained in both directions while neither full nor a
// held pop stalls the flow; a result reaches the result ports through the
// command queue, then the palette read register, then the result queue write.
// The palette RAM read port sets the pipeline depth.
// Reset restores the register defaults and clears 256 palette valid bits at
// once; no clearing pass. The 2-entry command queue and 4-entry result queue
// absorb stalls on either side independently.
// ----------------------------------------------------------------------------
module palette_pixel_blit_with_key_and_clip import rpb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic                   command_i,
  input  logic [7:0]             entry_index_i,
  input  logic [7:0]             red_i,
  input  logic [7:0]             green_i,
  input  logic [7:0]             blue_i,
  input  logic [31:0]            source_pixel_i,
  input  logic [COORD_WIDTH-1:0] dest_x_i,
  input  logic [COORD_WIDTH-1:0] dest_y_i,
  output logic                   empty,
  input  logic                   pop,
  output logic                   write_enable_o,
  output logic [COORD_WIDTH-1:0] out_x_o,
  output logic [COORD_WIDTH-1:0] out_y_o,
  output logic [31:0]            out_value_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  cfg_t       cfg_q;
  cmd_t       front_cmd, mid_cmd;
  logic       mid_push_ready, mid_valid, mid_ready, res_valid;
  result_t    res;
  bk_status_t bk_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= MODE_INDEXED;
      cfg_q.key_en    <= 1'b0;
      cfg_q.key       <= '0;
      cfg_q.left      <= '0;
      cfg_q.top       <= '0;
      cfg_q.width     <= CLIP_RESET;
      cfg_q.height    <= CLIP_RESET;
      cfg_q.pal_count <= COUNT_RESET;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_BLIT_MODE:     cfg_q.mode      <= mode_e'(cfg_data_i[1:0]);
        REG_KEY_ENABLE:    cfg_q.key_en    <= cfg_data_i[0];
        REG_KEY_VALUE:     cfg_q.key       <= cfg_data_i[31:0];
        REG_CLIP_LEFT:     cfg_q.left      <= cfg_data_i[EDGE_W-1:0];
        REG_CLIP_TOP:      cfg_q.top       <= cfg_data_i[EDGE_W-1:0];
        REG_CLIP_WIDTH:    cfg_q.width     <= cfg_data_i[CLIP_W-1:0];
        REG_CLIP_HEIGHT:   cfg_q.height    <= cfg_data_i[CLIP_W-1:0];
        REG_PALETTE_COUNT: cfg_q.pal_count <= cfg_data_i[PAL_CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rpb_front u_front (
    .cfg_i          (cfg_q),
    .command_i      (command_i),
    .entry_index_i  (entry_index_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .source_pixel_i (source_pixel_i),
    .dest_x_i       (dest_x_i),
    .dest_y_i       (dest_y_i),
    .cmd_o          (front_cmd)
  );

  rpb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push),
    .push_ready_o (mid_push_ready),
    .push_data_i  (front_cmd),
    .pop_valid_o  (mid_valid),
    .pop_ready_i  (mid_ready),
    .pop_data_o   (mid_cmd)
  );

  rpb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (mid_valid),
    .cmd_ready_o (mid_ready),
    .cmd_i       (mid_cmd),
    .res_valid_o (res_valid),
    .res_pop_i   (pop),
    .res_o       (res),
    .status_o    (bk_status)
  );

  assign full           = !mid_push_ready;
  assign empty          = !res_valid;
  assign write_enable_o = res.we;
  assign out_x_o        = res.x;
  assign out_y_o        = res.y;
  assign out_value_o    = res.value;

`ifndef ASSERT_OFF
  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((OUT_CNT_W + 1)'(bk_status.count) + (OUT_CNT_W + 1)'(bk_status.busy))
      <= (OUT_CNT_W + 1)'(OUT_DEPTH))
    else $error("result queue overcommitted");

  a_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_valid && mid_ready |=> bk_status.busy)
    else $error("issued command not in lookup stage");

  a_enqueue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full |=> mid_valid)
    else $error("accepted beat missing from command queue");
`endif

endmodule
